// ===== hw/rtl/drw_pkg.sv =====
// Shared types and constants for the dictionary record walker.
// No dependencies; drw_mul, the top level and the testbench import this package.
package drw_pkg;

  // Default width of the character-count field that opens each record
  localparam int unsigned CountFieldBytesDef = 1;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 3;

  localparam int unsigned MulAW   = 16;  // multiplicand: char count or word total
  localparam int unsigned MulBW   = 12;  // multiplier: bytes per char or entry size
  localparam int unsigned MulPW   = MulAW + MulBW;
  localparam int unsigned AccW    = 32;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_LEN       = 3'd0,
    CFG_SECOND_LEN      = 3'd1,
    CFG_FIRST_KEY_CHAR  = 3'd2,
    CFG_SECOND_KEY_CHAR = 3'd3,
    CFG_COUNT_FIELD     = 3'd4,
    CFG_WORD_CHAR       = 3'd5,
    CFG_TONE_CHAR       = 3'd6,
    CFG_FREQ            = 3'd7
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic [CfgDataW-1:0] FirstLenRst      = 3'd1;
  localparam logic [CfgDataW-1:0] SecondLenRst     = 3'd1;
  localparam logic [CfgDataW-1:0] FirstKeyCharRst  = 3'd1;
  localparam logic [CfgDataW-1:0] SecondKeyCharRst = 3'd1;
  localparam logic [CfgDataW-1:0] CountFieldRst    = 3'd2;
  localparam logic [CfgDataW-1:0] WordCharRst      = 3'd2;
  localparam logic [CfgDataW-1:0] ToneCharRst      = 3'd0;
  localparam logic [CfgDataW-1:0] FreqRst          = 3'd2;

  // Parse phase of the current record
  typedef enum logic [1:0] {
    PH_HEAD  = 2'd0,
    PH_COUNT = 2'd1,
    PH_BODY  = 2'd2
  } phase_e;

  // Sequencer state
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ENTRY = 2'd1,
    ST_REM   = 2'd2
  } seq_state_e;

  typedef struct packed {
    logic             start;
    logic [MulAW-1:0] mcand;
    logic [MulBW-1:0] mplier;
    logic [AccW-1:0]  addend;
  } mul_cmd_t;

  typedef struct packed {
    logic            busy;
    logic [AccW-1:0] result;
  } mul_sts_t;

  typedef struct packed {
    logic [31:0] record_offset;
    logic [7:0]  char_count;
    logic [7:0]  first_key_len;
    logic [7:0]  second_key_len;
    logic [15:0] word_total;
    logic [31:0] record_length;
    logic        truncated;
    logic        region_done;
  } rec_t;

endpackage

// ===== hw/rtl/drw_if.sv =====
// Handshake channels of the dictionary record walker: byte input and record output.
// No dependencies.
interface drw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_region;

  modport source (output valid, output data_byte, output end_of_region, input ready);
  modport sink   (input valid, input data_byte, input end_of_region, output ready);
endinterface

interface drw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] record_offset;
  logic [7:0]  char_count;
  logic [7:0]  first_key_len;
  logic [7:0]  second_key_len;
  logic [15:0] word_total;
  logic [31:0] record_length;
  logic        truncated;
  logic        region_done;

  modport source (output valid, output record_offset, output char_count,
                  output first_key_len, output second_key_len, output word_total,
                  output record_length, output truncated, output region_done,
                  input ready);
  modport sink   (input valid, input record_offset, input char_count,
                  input first_key_len, input second_key_len, input word_total,
                  input record_length, input truncated, input region_done,
                  output ready);
endinterface

// ===== hw/rtl/drw_mul.sv =====
// Shared shift-add multiply-accumulate unit, one multiplier bit per cycle.
// Depends on drw_pkg.
module drw_mul import drw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_cmd_t cmd_i,
  output mul_sts_t sts_o
);

  logic [MulPW-1:0] mcand_q;
  logic [MulBW-1:0] mplier_q;
  logic [AccW-1:0]  acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mplier_q <= '0;
    end else if (cmd_i.start) begin
      mplier_q <= cmd_i.mplier;
    end else if (mplier_q != '0) begin
      mplier_q <= mplier_q >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mcand_q <= MulPW'(cmd_i.mcand);
      acc_q   <= cmd_i.addend;
    end else if (mplier_q != '0) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + AccW'(mcand_q);
      end
      mcand_q <= mcand_q << 1;
    end
  end

  // Stop as soon as no multiplier bits remain
  assign sts_o.busy   = (mplier_q != '0);
  assign sts_o.result = acc_q;

endmodule

// ===== hw/rtl/dict_record_walker_top.sv =====
// Top level of the dictionary record walker: byte parser, sequencer and output register.
// Depends on drw_pkg, drw_if (drw_in_if, drw_out_if) and drw_mul.
//
// The walker takes the record region of a binary dictionary one byte per word on in_i
// and returns one word on out_o for each record it frames: start offset, character
// count, both key-length bytes, word total and record length, with truncated set when
// the region (marked by end_of_region on its last byte) ends inside a record. Header,
// key and body bytes are taken at one byte per cycle while the output register is free.
// The byte that completes the 16-bit word total starts the body-length computation,
// (word+tone bytes)*chars+freq and then total*entry, on a shared shift-add unit that
// retires one multiplier bit per cycle; input ready stays low for that time, once per
// record, while the sequencer hands each product on in ST_ENTRY and then ST_REM. A word
// waiting in the output register holds input ready low until the receiver takes it.
// Layout registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must
// write them only while the block is idle, which the block itself does not enforce.
module dict_record_walker_top import drw_pkg::*; #(
  parameter int unsigned COUNT_FIELD_BYTES = CountFieldBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  drw_in_if.sink              in_i,
  drw_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Offset of the first key-length byte inside a record
  localparam logic [15:0] Off1 = 16'(COUNT_FIELD_BYTES);

  // Layout registers
  logic [CfgDataW-1:0] flb_q, slb_q, fkc_q, skc_q, cfb_q, wcb_q, tcb_q, fb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flb_q <= FirstLenRst;
      slb_q <= SecondLenRst;
      fkc_q <= FirstKeyCharRst;
      skc_q <= SecondKeyCharRst;
      cfb_q <= CountFieldRst;
      wcb_q <= WordCharRst;
      tcb_q <= ToneCharRst;
      fb_q  <= FreqRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FIRST_LEN:       flb_q <= cfg_data_i;
        CFG_SECOND_LEN:      slb_q <= cfg_data_i;
        CFG_FIRST_KEY_CHAR:  fkc_q <= cfg_data_i;
        CFG_SECOND_KEY_CHAR: skc_q <= cfg_data_i;
        CFG_COUNT_FIELD:     cfb_q <= cfg_data_i;
        CFG_WORD_CHAR:       wcb_q <= cfg_data_i;
        CFG_TONE_CHAR:       tcb_q <= cfg_data_i;
        CFG_FREQ:            fb_q  <= cfg_data_i;
        default:             flb_q <= flb_q;
      endcase
    end
  end

  // Walk state
  seq_state_e  state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d, start_q, start_d, skip_q, skip_d;
  logic [7:0]  cc_q, cc_d, fl_q, fl_d, sl_q, sl_d;
  logic [15:0] wt_q, wt_d;
  logic [31:0] rel_q, rel_d;
  logic        eor_q, eor_d;

  // Output register
  rec_t        out_q, rec;
  logic        out_vld_q;
  logic        out_free, in_rdy, accept, emit, done_c, clear;

  mul_cmd_t    mul_cmd;
  mul_sts_t    mul_sts;

  // Header decode
  logic [31:0] rel;
  logic [7:0]  cc_n, fl_n, sl_n;
  logic [15:0] off2, addr;
  logic [8:0]  sum1, sum2;
  logic [11:0] prod1, prod2;
  logic        hit;
  logic [31:0] skip_n;
  logic [2:0]  cfb_adj;

  drw_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mul_cmd),
    .sts_o  (mul_sts)
  );

  assign out_free = !out_vld_q || out_o.ready;
  assign in_rdy   = (state_q == ST_IDLE) && out_free;
  assign accept   = in_i.valid && in_rdy;
  assign in_i.ready = in_rdy;

  // Position inside the record and the fields as they stand after this byte
  always_comb begin
    rel   = pos_q - start_q;
    cc_n  = (rel == 32'd0) ? in_i.data_byte : cc_q;
    fl_n  = (rel == 32'(Off1)) ? in_i.data_byte : fl_q;
    off2  = Off1 + ((slb_q != '0) ? 16'(flb_q) : 16'd0);
    sl_n  = (rel == 32'(off2)) ? in_i.data_byte : sl_q;
    sum1  = 9'(fl_n) + 9'(cc_n);
    sum2  = 9'(sl_n) + 9'(cc_n);
    prod1 = 12'(fkc_q) * 12'(sum1);
    prod2 = 12'(skc_q) * 12'(sum2);
    addr  = Off1 + 16'(flb_q) + 16'(slb_q) + 16'(prod1) + 16'(prod2);
    hit   = (rel >= 32'(off2)) && (rel == 32'(addr));
    skip_n  = (skip_q != 32'd0) ? skip_q - 32'd1 : 32'd0;
    // The word total always takes two bytes; the rest of the field is skipped
    cfb_adj = (cfb_q < 3'd2) ? 3'd0 : cfb_q - 3'd2;
  end

  // Sequencer: next state, walk state and result
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    pos_d   = pos_q;
    start_d = start_q;
    skip_d  = skip_q;
    cc_d    = cc_q;
    fl_d    = fl_q;
    sl_d    = sl_q;
    wt_d    = wt_q;
    rel_d   = rel_q;
    eor_d   = eor_q;
    mul_cmd = '0;
    emit    = 1'b0;
    done_c  = 1'b0;
    rec     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pos_d = in_i.end_of_region ? 32'd0 : pos_q + 32'd1;
          unique case (phase_q)
            PH_HEAD: begin
              cc_d = cc_n;
              fl_d = fl_n;
              sl_d = sl_n;
              if (hit) begin
                wt_d    = {8'd0, in_i.data_byte};
                phase_d = PH_COUNT;
              end
              emit = in_i.end_of_region;
            end
            PH_COUNT: begin
              // High byte of the word total: start the entry size multiply
              wt_d           = {in_i.data_byte, wt_q[7:0]};
              rel_d          = rel;
              eor_d          = in_i.end_of_region;
              state_d        = ST_ENTRY;
              mul_cmd.start  = 1'b1;
              mul_cmd.mcand  = MulAW'(cc_q);
              mul_cmd.mplier = MulBW'(wcb_q) + MulBW'(tcb_q);
              mul_cmd.addend = AccW'(fb_q);
            end
            PH_BODY: begin
              skip_d = skip_n;
              done_c = (skip_n == 32'd0);
              emit   = done_c || in_i.end_of_region;
            end
            default: phase_d = PH_HEAD;
          endcase
          rec.record_offset  = start_q;
          rec.char_count     = cc_d;
          rec.first_key_len  = fl_d;
          rec.second_key_len = sl_d;
          rec.word_total     = wt_d;
          rec.record_length  = rel + 32'd1;
          rec.truncated      = !done_c;
          rec.region_done    = in_i.end_of_region;
          if (emit) begin
            start_d = in_i.end_of_region ? 32'd0 : pos_q + 32'd1;
          end
        end
      end
      ST_ENTRY: begin
        // Entry size ready: multiply by the word total
        if (!mul_sts.busy) begin
          mul_cmd.start  = 1'b1;
          mul_cmd.mcand  = wt_q;
          mul_cmd.mplier = mul_sts.result[MulBW-1:0];
          mul_cmd.addend = AccW'(cfb_adj);
          state_d        = ST_REM;
        end
      end
      ST_REM: begin
        // Body length ready: close an empty body or an ended region at once, else start skipping
        if (!mul_sts.busy && out_free) begin
          state_d = ST_IDLE;
          done_c  = (mul_sts.result == 32'd0);
          emit    = done_c || eor_q;
          if (!done_c) begin
            skip_d  = mul_sts.result;
            phase_d = PH_BODY;
          end
          rec.record_offset  = start_q;
          rec.char_count     = cc_q;
          rec.first_key_len  = fl_q;
          rec.second_key_len = sl_q;
          rec.word_total     = wt_q;
          rec.record_length  = rel_q + 32'd1;
          rec.truncated      = !done_c;
          rec.region_done    = eor_q;
          if (emit) begin
            start_d = eor_q ? 32'd0 : pos_q;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Drop the record state once it has been reported
    clear = emit;
    if (clear) begin
      phase_d = PH_HEAD;
      cc_d    = '0;
      fl_d    = '0;
      sl_d    = '0;
      wt_d    = '0;
      skip_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_HEAD;
      pos_q   <= '0;
      start_q <= '0;
      skip_q  <= '0;
      cc_q    <= '0;
      fl_q    <= '0;
      sl_q    <= '0;
      wt_q    <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      skip_q  <= skip_d;
      cc_q    <= cc_d;
      fl_q    <= fl_d;
      sl_q    <= sl_d;
      wt_q    <= wt_d;
    end
  end

  // Hold the offset and region end of the byte that finished the word total
  always_ff @(posedge clk_i) begin
    rel_q <= rel_d;
    eor_q <= eor_d;
  end

  // Output register: load a new word when the slot is free, drop it when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= rec;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.record_offset  = out_q.record_offset;
  assign out_o.char_count     = out_q.char_count;
  assign out_o.first_key_len  = out_q.first_key_len;
  assign out_o.second_key_len = out_q.second_key_len;
  assign out_o.word_total     = out_q.word_total;
  assign out_o.record_length  = out_q.record_length;
  assign out_o.truncated      = out_q.truncated;
  assign out_o.region_done    = out_q.region_done;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for dict_record_walker_top: random and directed byte streams.
// Depends on drw_pkg, drw_if (drw_in_if, drw_out_if) and the walker RTL.
`timescale 1ns / 100ps

module tb_top import drw_pkg::*; ();

  localparam int unsigned CharCountBytes = CountFieldBytesDef;
  localparam int unsigned SettleCycles   = 40;    // longer than one body-length multiply
  localparam int unsigned QuietLimit     = 3000;  // cycles without any word moving
  localparam int unsigned PhaseBytes     = 165;
  localparam int unsigned NumPhases      = 9;
  localparam int unsigned MaxRecordBytes = 600;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } region_byte_t;

  logic clk_i;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  drw_in_if  in_if ();
  drw_out_if out_if ();

  dict_record_walker_top #(
    .COUNT_FIELD_BYTES(CharCountBytes)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Bytes waiting to be driven, and records the walker still owes us
  region_byte_t region_bytes[$];
  rec_t         owed_records[$];

  int unsigned bytes_queued;
  int unsigned bytes_taken;
  int unsigned bad_records;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Layout registers as the walker should hold them
  logic [2:0] lay_first_len, lay_second_len, lay_first_key, lay_second_key;
  logic [2:0] lay_count_field, lay_word_char, lay_tone_char, lay_freq;

  // Walk state of the predictor
  phase_e      walk_phase;
  logic [31:0] walk_pos;
  logic [31:0] walk_start;
  logic [31:0] body_left;
  logic [7:0]  hold_cc;
  logic [7:0]  hold_len1;
  logic [7:0]  hold_len2;
  logic [15:0] hold_words;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Advance the predictor by one byte; return 1 when that byte closes a record.
  function automatic bit walk_byte(input logic [7:0] b, input logic last, output rec_t rec);
    logic [31:0] rel;
    logic [63:0] off1, off2, key_end, cfb, entry, body;
    bit          closed;
    rec = '0;
    closed = 1'b0;
    rel = walk_pos - walk_start;
    off1 = 64'(CharCountBytes);
    off2 = off1 + ((lay_second_len != 3'd0) ? 64'(lay_first_len) : 64'd0);
    case (walk_phase)
      PH_HEAD: begin
        // Length bytes are caught at fixed offsets, wherever the layout puts them
        if (rel == 32'd0) hold_cc = b;
        if (64'(rel) == off1) hold_len1 = b;
        if (64'(rel) == off2) hold_len2 = b;
        key_end = off1 + 64'(lay_first_len) + 64'(lay_second_len)
                + 64'(lay_first_key) * (64'(hold_len1) + 64'(hold_cc))
                + 64'(lay_second_key) * (64'(hold_len2) + 64'(hold_cc));
        if (64'(rel) >= off2 && 64'(rel) == key_end) begin
          hold_words = {8'd0, b};
          walk_phase = PH_COUNT;
        end
      end
      PH_COUNT: begin
        // Count field narrower than the word total still spans two bytes
        cfb = (lay_count_field < 3'd2) ? 64'd2 : 64'(lay_count_field);
        hold_words[15:8] = b;
        entry = (64'(lay_word_char) + 64'(lay_tone_char)) * 64'(hold_cc) + 64'(lay_freq);
        body = (cfb - 64'd2) + 64'(hold_words) * entry;
        if (body == 64'd0) begin
          closed = 1'b1;
        end else begin
          body_left = body[31:0];
          walk_phase = PH_BODY;
        end
      end
      default: begin
        if (body_left != 32'd0) body_left = body_left - 32'd1;
        if (body_left == 32'd0) closed = 1'b1;
      end
    endcase
    walk_pos = walk_pos + 32'd1;
    if (!(closed || last)) return 1'b0;
    rec.record_offset  = walk_start;
    rec.char_count     = hold_cc;
    rec.first_key_len  = hold_len1;
    rec.second_key_len = hold_len2;
    rec.word_total     = hold_words;
    rec.record_length  = rel + 32'd1;
    rec.truncated      = !closed;
    rec.region_done    = last;
    walk_phase = PH_HEAD;
    hold_cc = '0;
    hold_len1 = '0;
    hold_len2 = '0;
    hold_words = '0;
    body_left = '0;
    // A region end restarts offsets at zero
    if (last) begin
      walk_pos = '0;
      walk_start = '0;
    end else begin
      walk_start = walk_pos;
    end
    return 1'b1;
  endfunction

  function automatic string fmt_rec(input rec_t r);
    return $sformatf("off=%0h cc=%0h len1=%0h len2=%0h words=%0h len=%0h trunc=%0b done=%0b",
                     r.record_offset, r.char_count, r.first_key_len, r.second_key_len,
                     r.word_total, r.record_length, r.truncated, r.region_done);
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic last);
    region_byte_t w;
    w.data = b;
    w.last = last;
    region_bytes.push_back(w);
    bytes_queued++;
  endtask

  // Random bytes, the last one closing the region
  task automatic queue_noise(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) queue_byte(8'($urandom), i == n - 1);
  endtask

  // Queue one well-formed record under the current layout, random where the layout
  // leaves bytes free. Optionally cut it short or close the region on its last byte.
  task automatic queue_record(input logic [7:0] cc, input logic [7:0] l1, input logic [7:0] l2,
                              input logic [15:0] wt, input bit cut, input bit close);
    logic [63:0] off1, off2, key_end, cfb, entry, total;
    int unsigned sent;
    logic [7:0]  b;
    off1 = 64'(CharCountBytes);
    forever begin
      off2 = off1 + ((lay_second_len != 3'd0) ? 64'(lay_first_len) : 64'd0);
      if (off2 == off1) l2 = l1;
      key_end = off1 + 64'(lay_first_len) + 64'(lay_second_len)
              + 64'(lay_first_key) * (64'(l1) + 64'(cc))
              + 64'(lay_second_key) * (64'(l2) + 64'(cc));
      // When the keys end where the first length byte sits, that byte doubles as the word-total low byte
      if (key_end == off1) wt[7:0] = l1;
      cfb = (lay_count_field < 3'd2) ? 64'd2 : 64'(lay_count_field);
      entry = (64'(lay_word_char) + 64'(lay_tone_char)) * 64'(cc) + 64'(lay_freq);
      total = key_end + cfb + 64'(wt) * entry;
      if (total <= 64'(MaxRecordBytes)) break;
      cc = cc >> 1;
      l1 = l1 >> 1;
      l2 = l2 >> 1;
      wt = wt >> 1;
    end
    sent = cut ? $urandom_range(1, 32'(total) - 1) : 32'(total);
    for (int unsigned i = 0; i < sent; i++) begin
      if (i == 0) b = cc;
      else if (64'(i) == off1) b = l1;
      else if (64'(i) == off2) b = l2;
      else if (64'(i) == key_end) b = wt[7:0];
      else if (64'(i) == key_end + 64'd1) b = wt[15:8];
      else b = 8'($urandom);
      queue_byte(b, (i == sent - 1) && (cut || close));
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [2:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    case (idx)
      CFG_FIRST_LEN:       lay_first_len   = v;
      CFG_SECOND_LEN:      lay_second_len  = v;
      CFG_FIRST_KEY_CHAR:  lay_first_key   = v;
      CFG_SECOND_KEY_CHAR: lay_second_key  = v;
      CFG_COUNT_FIELD:     lay_count_field = v;
      CFG_WORD_CHAR:       lay_word_char   = v;
      CFG_TONE_CHAR:       lay_tone_char   = v;
      default:             lay_freq        = v;
    endcase
  endtask

  // Fields packed low to high: first len, second len, first key, second key,
  // count field, word char, tone char, freq.
  task automatic apply_layout(input logic [23:0] lay);
    write_reg(CFG_FIRST_LEN,       lay[2:0]);
    write_reg(CFG_SECOND_LEN,      lay[5:3]);
    write_reg(CFG_FIRST_KEY_CHAR,  lay[8:6]);
    write_reg(CFG_SECOND_KEY_CHAR, lay[11:9]);
    write_reg(CFG_COUNT_FIELD,     lay[14:12]);
    write_reg(CFG_WORD_CHAR,       lay[17:15]);
    write_reg(CFG_TONE_CHAR,       lay[20:18]);
    write_reg(CFG_FREQ,            lay[23:21]);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Layout of each random phase: hand-picked corners first, then random settings
  function automatic logic [23:0] phase_layout(input int unsigned ph);
    case (ph)
      // shared and overlapping length bytes, count field below two bytes
      0: return {3'd1, 3'd1, 3'd1, 3'd0, 3'd2, 3'd1, 3'd0, 3'd0};
      1: return {8{3'd7}};   // every register at its top
      2: return {8{3'd4}};   // every register at 4, its top bit alone set
      // keys absent, empty word entries, so any word total costs no body
      3: return {3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0, 3'd2};
      default: return 24'($urandom);
    endcase
  endfunction

  // Wait until every queued byte is taken and every record is back, then let any
  // multiply still running finish.
  task automatic drain();
    while (bytes_taken != bytes_queued || owed_records.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Byte driver: hold a word until it is taken, then advance or idle at random
  always @(posedge clk_i) begin : drive_bytes
    region_byte_t w;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (region_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        w = region_bytes.pop_front();
        in_if.valid         <= 1'b1;
        in_if.data_byte     <= w.data;
        in_if.end_of_region <= w.last;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Record receiver: stall at random
  always @(posedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: predict on every byte taken, check every record returned
  always @(posedge clk_i) begin : watch_words
    rec_t got;
    rec_t want;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (in_if.valid && in_if.ready) begin
        bytes_taken++;
        if (walk_byte(in_if.data_byte, in_if.end_of_region, want)) owed_records.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        got.record_offset  = out_if.record_offset;
        got.char_count     = out_if.char_count;
        got.first_key_len  = out_if.first_key_len;
        got.second_key_len = out_if.second_key_len;
        got.word_total     = out_if.word_total;
        got.record_length  = out_if.record_length;
        got.truncated      = out_if.truncated;
        got.region_done    = out_if.region_done;
        if (owed_records.size() == 0) begin
          bad_records++;
          if (bad_records <= 10) $display("%0t: unexpected record %s", $time, fmt_rec(got));
        end else begin
          want = owed_records.pop_front();
          if (got.record_offset !== want.record_offset || got.char_count !== want.char_count ||
              got.first_key_len !== want.first_key_len ||
              got.second_key_len !== want.second_key_len ||
              got.word_total !== want.word_total || got.record_length !== want.record_length ||
              got.truncated !== want.truncated || got.region_done !== want.region_done) begin
            bad_records++;
            if (bad_records <= 10) begin
              $display("%0t: record differs", $time);
              $display("  expected %s", fmt_rec(want));
              $display("  actual   %s", fmt_rec(got));
            end
          end
        end
      end
    end
  end

  // Watchdog: nothing moving for too long ends the run
  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("dict_record_walker_top: mismatch");
    $finish;
  end

  initial begin
    logic [7:0]  cc, l1, l2;
    logic [15:0] wt;
    int unsigned kind, phase_first;

    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    in_if.end_of_region = 1'b0;
    out_if.ready        = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_FIRST_LEN;
    cfg_data_i          = '0;
    rst_ni              = 1'b0;
    bytes_queued = 0;
    bytes_taken  = 0;
    bad_records  = 0;
    quiet_cycles = 0;
    send_idle_pct  = 10;
    recv_stall_pct = 71;

    // Layout and walk state right after reset
    lay_first_len   = FirstLenRst;
    lay_second_len  = SecondLenRst;
    lay_first_key   = FirstKeyCharRst;
    lay_second_key  = SecondKeyCharRst;
    lay_count_field = CountFieldRst;
    lay_word_char   = WordCharRst;
    lay_tone_char   = ToneCharRst;
    lay_freq        = FreqRst;
    walk_phase = PH_HEAD;
    walk_pos   = '0;
    walk_start = '0;
    body_left  = '0;
    hold_cc    = '0;
    hold_len1  = '0;
    hold_len2  = '0;
    hold_words = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: smallest record, a record with keys and one entry closing the region,
    // a region that ends mid-record, then a layout change under a half-read header.
    queue_record(8'd0, 8'd0, 8'd0, 16'd0, 1'b0, 1'b0);
    queue_record(8'd1, 8'd0, 8'd1, 16'd1, 1'b0, 1'b1);
    queue_noise(3);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hff, 1'b0);
    drain();
    // The next byte closes the region while the word total under the new layout still
    // lies ahead, so this record can only end truncated.
    apply_layout(phase_layout(0));
    queue_byte(8'h55, 1'b1);

    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      // Sender mostly busy first, then receiver mostly ready, then no idling at all
      case (ph / 3)
        0: begin
          send_idle_pct  = 10;
          recv_stall_pct = 71;
        end
        1: begin
          send_idle_pct  = 71;
          recv_stall_pct = 10;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (ph != 0) begin
        drain();
        apply_layout(phase_layout(ph));
      end
      phase_first = bytes_queued;
      while (bytes_queued - phase_first < PhaseBytes) begin
        kind = $urandom_range(0, 99);
        cc = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        l1 = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        l2 = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        wt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        if (kind < 8) queue_noise($urandom_range(1, 10));
        else queue_record(cc, l1, l2, wt, kind < 20, kind >= 20 && kind < 28);
      end
      // Close the region so the phase ends on a record
      queue_byte(8'($urandom), 1'b1);
    end

    drain();
    if (bad_records == 0 && owed_records.size() == 0) begin
      $display("dict_record_walker_top: match");
    end else begin
      $display("dict_record_walker_top: mismatch");
    end
    $finish;
  end

endmodule
